### rtl/core/mttsm_pkg.sv
// Shared types and constants for the MIDI tick to sample tempo map unit.
package mttsm_pkg;

    // Field widths
    localparam int CMD_W      = 2;
    localparam int TICK_W     = 32;
    localparam int QUS_W      = 24;
    localparam int TPQ_W      = 15;
    localparam int RATE_W     = 20;
    localparam int POS_W      = 31;
    localparam int DEN_W      = 35;
    localparam int DPROD_W    = TICK_W + QUS_W;
    localparam int SUM_W      = 65;
    localparam int S_TDATA_W  = 56;
    localparam int M_TDATA_W  = 32;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 20;

    // Command codes (s_tuser)
    localparam logic [CMD_W-1:0] CMD_CHANNEL   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TEMPO     = 2'd1;
    localparam logic [CMD_W-1:0] CMD_OTHER     = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NEW_TRACK = 2'd3;

    // Register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_TPQ  = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_RATE = 1'b1;

    // Constants
    localparam logic [TPQ_W-1:0]  DEFAULT_TPQ        = 15'd480;
    localparam logic [RATE_W-1:0] DEFAULT_RATE       = 20'd44100;
    localparam logic [QUS_W-1:0]  DEFAULT_QUARTER_US = 24'd500000;
    localparam logic [RATE_W-1:0] US_PER_SECOND      = 20'd1000000;
    localparam logic [POS_W-1:0]  POS_MAX            = 31'h7FFF_FFFF;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL1,
        ST_SUM,
        ST_MUL2,
        ST_DIV,
        ST_DONE
    } state_t;

endpackage

### rtl/core/mttsm_serial_mul.sv
// Bit-serial shift-add multiplier, multiplier bits taken MSB first.
module mttsm_serial_mul #(
    parameter int A_W = 32,
    parameter int B_W = 24
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [A_W-1:0]     a,
    input  logic [B_W-1:0]     b,
    output logic               done,
    output logic [A_W+B_W-1:0] product
);

    localparam int P_W   = A_W + B_W;
    localparam int CNT_W = $clog2(B_W);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [A_W-1:0]   a_reg;
    logic [B_W-1:0]   b_sh_reg;
    logic [P_W-1:0]   acc_reg;
    logic [P_W-1:0]   acc_next;

    always_comb begin
        acc_next = {acc_reg[P_W-2:0], 1'b0} + (b_sh_reg[B_W-1] ? P_W'(a_reg) : '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(B_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg    <= a;
            b_sh_reg <= b;
            acc_reg  <= '0;
        end else if (busy_reg) begin
            b_sh_reg <= {b_sh_reg[B_W-2:0], 1'b0};
            acc_reg  <= acc_next;
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

### rtl/core/mttsm_serial_div.sv
// Restoring bit-serial divider with a short quotient and an overflow flag.
module mttsm_serial_div #(
    parameter int N_W = 84,
    parameter int D_W = 35,
    parameter int Q_W = 31
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           start,
    input  logic [N_W-1:0] num,
    input  logic [D_W-1:0] den,
    output logic           done,
    output logic           over,
    output logic [Q_W-1:0] quot
);

    localparam int CNT_W = $clog2(Q_W);
    localparam int HI_W  = N_W - Q_W;

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             over_reg;
    logic [D_W-1:0]   den_reg;
    logic [D_W-1:0]   rem_reg;
    logic [Q_W-1:0]   lo_sh_reg;
    logic [Q_W-1:0]   quot_reg;

    logic [D_W:0]     trial;
    logic [D_W:0]     diff;
    logic             ge;
    logic [D_W-1:0]   rem_next;

    always_comb begin
        trial    = {rem_reg, lo_sh_reg[Q_W-1]};
        diff     = trial - {1'b0, den_reg};
        ge       = (trial >= {1'b0, den_reg});
        rem_next = ge ? diff[D_W-1:0] : trial[D_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(Q_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // quotient >= 2^Q_W exactly when the high part of num reaches den;
    // otherwise the high part is below den and seeds the remainder
    always_ff @(posedge aclk) begin
        if (start) begin
            over_reg  <= (num[N_W-1:Q_W] >= HI_W'(den));
            den_reg   <= den;
            rem_reg   <= num[Q_W+D_W-1:Q_W];
            lo_sh_reg <= num[Q_W-1:0];
            quot_reg  <= '0;
        end else if (busy_reg) begin
            rem_reg   <= rem_next;
            lo_sh_reg <= {lo_sh_reg[Q_W-2:0], 1'b0};
            quot_reg  <= {quot_reg[Q_W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign over = over_reg;
    assign quot = quot_reg;

endmodule

### rtl/core/midi_tick_to_sample_tempo_map_unit.sv
// Top level: MIDI tick to sample position converter over a running tempo map.
// A channel or tempo word gives its result word after a tick*tempo multiply, an add,
//   a time*rate multiply and a divide, with registered handoffs between the steps.
// The input is held not ready from the accept of an event word until its result is loaded into the
//   output register; other-meta and new-track words are accepted while idle and give no result.
// Reset: sync active-low aresetn restores 480 tpq, 44100 Hz, 120 BPM at tick 0 / time 0.
module midi_tick_to_sample_tempo_map_unit #(
    parameter int TIME_ACC_WIDTH = 64
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // input words
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [31:0] event_tick, [55:32] quarter_note_us
    input  logic [mttsm_pkg::S_TDATA_W-1:0]  s_tdata,
    // [1:0] command
    input  logic [mttsm_pkg::CMD_W-1:0]      s_tuser,
    // result words
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [30:0] sample_position, [31] zero
    output logic [mttsm_pkg::M_TDATA_W-1:0]  m_tdata,
    // [0] saturated
    output logic [0:0]                       m_tuser,
    // configuration write port
    input  logic                             cfg_wr_en,
    input  logic [mttsm_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [mttsm_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    localparam int TW = TIME_ACC_WIDTH;
    localparam int NW = TIME_ACC_WIDTH + mttsm_pkg::RATE_W;

    mttsm_pkg::state_t state_reg, state_next;

    // configuration
    logic [mttsm_pkg::TPQ_W-1:0]  tpq_reg;
    logic [mttsm_pkg::RATE_W-1:0] rate_reg;

    // tempo segment
    logic [mttsm_pkg::TICK_W-1:0] seg_tick_reg;
    logic [TW-1:0]                seg_time_reg;
    logic [mttsm_pkg::QUS_W-1:0]  seg_q_reg;

    // captured event
    logic                         tempo_reg;
    logic [mttsm_pkg::TICK_W-1:0] tick_reg;
    logic [mttsm_pkg::QUS_W-1:0]  qus_reg;
    logic [mttsm_pkg::DEN_W-1:0]  den_reg;

    // result staging and output register
    logic [mttsm_pkg::POS_W-1:0]  res_pos_reg;
    logic                         res_sat_reg;
    logic                         m_tvalid_reg;
    logic [mttsm_pkg::POS_W-1:0]  m_pos_reg;
    logic                         m_sat_reg;

    // decoded input
    logic [mttsm_pkg::TICK_W-1:0] s_tick;
    logic [mttsm_pkg::QUS_W-1:0]  s_qus;
    logic                         cmd_is_event;
    logic                         accept;

    // datapath
    logic [mttsm_pkg::TICK_W-1:0] delta;
    logic [mttsm_pkg::TPQ_W-1:0]  tpq_eff;
    logic [mttsm_pkg::DEN_W-1:0]  den_next;
    logic [mttsm_pkg::SUM_W-1:0]  sum;
    logic [TW-1:0]                t_val;
    logic [mttsm_pkg::QUS_W-1:0]  new_q;

    // unit handshakes
    logic                          mul1_start, mul1_done;
    logic [mttsm_pkg::DPROD_W-1:0] mul1_prod;
    logic                          mul2_start, mul2_done;
    logic [NW-1:0]                 mul2_prod;
    logic                          div_start, div_done, div_over;
    logic [mttsm_pkg::POS_W-1:0]   div_quot;
    logic                          out_load;

    assign s_tick = s_tdata[mttsm_pkg::TICK_W-1:0];
    assign s_qus  = s_tdata[mttsm_pkg::TICK_W+mttsm_pkg::QUS_W-1:mttsm_pkg::TICK_W];
    assign accept = s_tvalid && s_tready;

    always_comb begin
        unique case (s_tuser) inside
            mttsm_pkg::CMD_CHANNEL, mttsm_pkg::CMD_TEMPO: cmd_is_event = 1'b1;
            default:                                      cmd_is_event = 1'b0;
        endcase
    end

    // ticks before the segment start count as zero elapsed ticks
    always_comb begin
        delta    = (s_tick > seg_tick_reg) ? (s_tick - seg_tick_reg) : '0;
        tpq_eff  = (tpq_reg == '0) ? mttsm_pkg::DEFAULT_TPQ : tpq_reg;
        den_next = mttsm_pkg::DEN_W'(tpq_eff) * mttsm_pkg::DEN_W'(mttsm_pkg::US_PER_SECOND);
    end

    // elapsed time = start + delta*tempo, clamped to the accumulator max
    always_comb begin
        sum   = mttsm_pkg::SUM_W'(seg_time_reg) + mttsm_pkg::SUM_W'(mul1_prod);
        t_val = (|sum[mttsm_pkg::SUM_W-1:TW]) ? {TW{1'b1}} : sum[TW-1:0];
        new_q = (qus_reg == '0) ? mttsm_pkg::DEFAULT_QUARTER_US : qus_reg;
    end

    // FSM next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            mttsm_pkg::ST_IDLE: if (accept && cmd_is_event) state_next = mttsm_pkg::ST_MUL1;
            mttsm_pkg::ST_MUL1: if (mul1_done) state_next = mttsm_pkg::ST_SUM;
            mttsm_pkg::ST_SUM:  state_next = mttsm_pkg::ST_MUL2;
            mttsm_pkg::ST_MUL2: if (mul2_done) state_next = mttsm_pkg::ST_DIV;
            mttsm_pkg::ST_DIV:  if (div_done) state_next = mttsm_pkg::ST_DONE;
            mttsm_pkg::ST_DONE: if (out_load) state_next = mttsm_pkg::ST_IDLE;
            default:            state_next = mttsm_pkg::ST_IDLE;
        endcase
    end

    // FSM outputs
    always_comb begin
        s_tready   = (state_reg == mttsm_pkg::ST_IDLE);
        mul1_start = (state_reg == mttsm_pkg::ST_IDLE) && s_tvalid && cmd_is_event;
        mul2_start = (state_reg == mttsm_pkg::ST_SUM);
        div_start  = (state_reg == mttsm_pkg::ST_MUL2) && mul2_done;
        out_load   = (state_reg == mttsm_pkg::ST_DONE) && (!m_tvalid_reg || m_tready);
    end

    // control, configuration and segment state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= mttsm_pkg::ST_IDLE;
            tpq_reg      <= mttsm_pkg::DEFAULT_TPQ;
            rate_reg     <= mttsm_pkg::DEFAULT_RATE;
            seg_tick_reg <= '0;
            seg_time_reg <= '0;
            seg_q_reg    <= mttsm_pkg::DEFAULT_QUARTER_US;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;

            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    mttsm_pkg::REG_TPQ:  tpq_reg  <= cfg_wdata[mttsm_pkg::TPQ_W-1:0];
                    mttsm_pkg::REG_RATE: rate_reg <= cfg_wdata;
                    default: ;
                endcase
            end

            // new track: back to 120 BPM at tick 0
            if (accept && (s_tuser == mttsm_pkg::CMD_NEW_TRACK)) begin
                seg_tick_reg <= '0;
                seg_time_reg <= '0;
                seg_q_reg    <= mttsm_pkg::DEFAULT_QUARTER_US;
            end else if ((state_reg == mttsm_pkg::ST_SUM) && tempo_reg) begin
                seg_tick_reg <= tick_reg;
                seg_time_reg <= t_val;
                seg_q_reg    <= new_q;
            end

            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            tempo_reg <= (s_tuser == mttsm_pkg::CMD_TEMPO);
            tick_reg  <= s_tick;
            qus_reg   <= s_qus;
            den_reg   <= den_next;
        end
        if (div_done) begin
            res_pos_reg <= div_over ? mttsm_pkg::POS_MAX : div_quot;
            res_sat_reg <= div_over;
        end
        if (out_load) begin
            m_pos_reg <= res_pos_reg;
            m_sat_reg <= res_sat_reg;
        end
    end

    // delta ticks * tempo
    mttsm_serial_mul #(
        .A_W (mttsm_pkg::TICK_W),
        .B_W (mttsm_pkg::QUS_W)
    ) u_mul_time (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul1_start),
        .a       (delta),
        .b       (seg_q_reg),
        .done    (mul1_done),
        .product (mul1_prod)
    );

    // elapsed time * sample rate
    mttsm_serial_mul #(
        .A_W (TIME_ACC_WIDTH),
        .B_W (mttsm_pkg::RATE_W)
    ) u_mul_rate (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul2_start),
        .a       (t_val),
        .b       (rate_reg),
        .done    (mul2_done),
        .product (mul2_prod)
    );

    // floor(time*rate / (tpq*1e6)); over flags a quotient past POS_MAX
    mttsm_serial_div #(
        .N_W (NW),
        .D_W (mttsm_pkg::DEN_W),
        .Q_W (mttsm_pkg::POS_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (mul2_prod),
        .den     (den_reg),
        .done    (div_done),
        .over    (div_over),
        .quot    (div_quot)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, m_pos_reg};
    assign m_tuser  = m_sat_reg;

endmodule
